// ----- design/tnd_pkg.sv -----
// Shared types, constants and arithmetic helpers for the five-point
// threshold denoise block. No dependencies.
package tnd_pkg;

  localparam int MaxLineBytes = 8192;
  localparam int AddrW        = $clog2(MaxLineBytes);
  localparam int ColW         = 13;
  localparam int RowW         = 12;
  localparam int LenW         = 13;
  localparam int ThrW         = 5;
  localparam int SumW         = 11;
  localparam int CntW         = 3;
  localparam int CfgIdxW      = 8;
  localparam int CfgDataW     = 13;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgStrength    = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgLineLength  = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgFrameRows   = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgInterleaved = 8'd3;

  localparam logic [LenW-1:0] LenMax = 13'd4096;
  localparam logic [6:0]      StrMax = 7'd100;

  typedef struct packed {
    logic [AddrW-1:0] k;
    logic [7:0]       center;
    logic [7:0]       left;
    logic [7:0]       right;
    logic [7:0]       down;
    logic             has_left;
    logic             has_right;
    logic             eol;
    logic             eof;
  } job_t;

  function automatic logic [6:0] clamp_strength(input logic [CfgDataW-1:0] data);
    logic [6:0] v;
    v = data[6:0];
    if (v == 7'd0) return 7'd1;
    if (v > StrMax) return StrMax;
    return v;
  endfunction

  function automatic logic [LenW-1:0] clamp_len(input logic [CfgDataW-1:0] data);
    logic [LenW-1:0] v;
    v = data[LenW-1:0];
    if (v == '0) return 13'd1;
    if (v > LenMax) return LenMax;
    return v;
  endfunction

  // max(2, s*30/100) = max(2, floor(3s/10)); /10 as *205 >> 11, exact for 3s <= 300
  function automatic logic [ThrW-1:0] thr_of(input logic [6:0] s);
    logic [8:0]  x3;
    logic [16:0] p;
    logic [ThrW-1:0] t;
    x3 = {2'b00, s} * 9'd3;
    p  = {8'b0, x3} * 17'd205;
    t  = p[11+ThrW-1:11];
    return (t < 5'd2) ? 5'd2 : t;
  endfunction

  // Truncating divide of a neighbor sum by a count of one to five
  function automatic logic [7:0] div_small(input logic [SumW-1:0] sum,
                                           input logic [CntW-1:0] cnt);
    logic [20:0] p3;
    logic [21:0] p5;
    logic [SumW-1:0] q;
    p3 = {10'b0, sum} * 21'd683;
    p5 = {11'b0, sum} * 22'd1639;
    case (cnt)
      3'd2:    q = {1'b0, sum[SumW-1:1]};
      3'd3:    q = {1'b0, p3[11+SumW-2:11]};
      3'd4:    q = {2'b00, sum[SumW-1:2]};
      3'd5:    q = {2'b00, p5[13+SumW-3:13]};
      default: q = sum;
    endcase
    return q[7:0];
  endfunction

endpackage

// ----- design/tnd_mean.sv -----
// Neighbor selection and mean for one byte: sum and count registered,
// then the truncating divide. Depends on tnd_pkg.
module tnd_mean (
  input  logic                    clk,
  input  logic                    calc_en,
  input  tnd_pkg::job_t           job,
  input  logic [7:0]              up_value,
  input  logic                    first_row,
  input  logic [tnd_pkg::ThrW-1:0] thr,
  output logic [7:0]              mean_value
);

  logic [tnd_pkg::SumW-1:0] sum_r, sum_nxt;
  logic [tnd_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic [7:0]               up;

  function automatic logic near(input logic [7:0] n, input logic [7:0] c,
                                input logic [tnd_pkg::ThrW-1:0] t);
    logic [7:0] diff;
    diff = (n > c) ? (n - c) : (c - n);
    return diff < {3'b000, t};
  endfunction

  always_comb begin
    up      = first_row ? job.center : up_value;
    sum_nxt = {3'b000, job.center};
    cnt_nxt = 3'd1;
    if (near(up, job.center, thr)) begin
      sum_nxt = sum_nxt + {3'b000, up};
      cnt_nxt = cnt_nxt + 3'd1;
    end
    if (near(job.down, job.center, thr)) begin
      sum_nxt = sum_nxt + {3'b000, job.down};
      cnt_nxt = cnt_nxt + 3'd1;
    end
    if (job.has_left && near(job.left, job.center, thr)) begin
      sum_nxt = sum_nxt + {3'b000, job.left};
      cnt_nxt = cnt_nxt + 3'd1;
    end
    if (job.has_right && near(job.right, job.center, thr)) begin
      sum_nxt = sum_nxt + {3'b000, job.right};
      cnt_nxt = cnt_nxt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_en) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign mean_value = tnd_pkg::div_small(sum_r, cnt_r);

endmodule

// ----- design/threshold_neighbor_denoise_top.sv -----
// Top level of the five-point threshold denoise filter: sequencer, row
// store, neighbor windows and output register. Depends on tnd_pkg, tnd_mean.
//
// Usage: send one beat per raster position on in_* (the original byte and
// the original byte one row below). Filtered bytes leave on out_* in raster
// order, trailing the input by one neighbor distance; end_of_line and
// end_of_frame mark row and plane ends, last_of_run closes the results of
// one input beat. Registers must be written on cfg_* (always ready) only
// while idle; the block itself does not enforce this. Sequencing: an input
// is taken in the idle state, then every filtered byte it completes passes
// through the read, accumulate, and divide-and-write-back steps on the
// single-port row store, after a step that sends any byte held over from
// the previous row end. An interleaved row end keeps its final byte and
// sends it first on the next beat.
// Reset (synchronous, rst_n low) clears windows, counters, registers to
// their defaults and drops any held byte; the row store is not cleared and
// its read data is ignored while the first row of a frame is filtered.
// A stalled receiver holds the output register; the sequencer waits before
// its write-back step and in_ready stays low until the beat is done.
module threshold_neighbor_denoise_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_center_value,
  input  logic [7:0]                  in_below_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_filtered_value,
  output logic                        out_end_of_line,
  output logic                        out_end_of_frame,
  output logic                        out_last_of_run,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tnd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [tnd_pkg::CfgDataW-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HELD = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_WR   = 3'd4;

  // configuration
  logic [tnd_pkg::ThrW-1:0] thr_r;
  logic [tnd_pkg::LenW-1:0] line_len_r, frame_rows_r;
  logic                     ilv_r;

  // stream state
  logic [7:0]               ow_r [4];
  logic [7:0]               bw_r [3];
  logic [tnd_pkg::ColW-1:0] col_r, col_nxt;
  logic [tnd_pkg::RowW-1:0] row_r, row_nxt;

  logic [2:0]               state_r, state_nxt;
  logic [2:0]               pend_r, pend_nxt;
  tnd_pkg::job_t            jobs_r [3];
  tnd_pkg::job_t            cur_r, sel_job;
  logic [1:0]               sel_idx;
  logic                     first_row_r;
  logic [1:0]               pos_r;
  logic                     last_pos_r;

  logic                     held_valid_r, held_valid_nxt;
  logic [7:0]               held_value_r;
  logic                     held_eol_r, held_eof_r;

  logic                     out_valid_r;
  logic [7:0]               out_value_r;
  logic                     out_eol_r, out_eof_r, out_last_r;

  logic [7:0]               store_mem [tnd_pkg::MaxLineBytes];
  logic [7:0]               rd_data_r;
  logic [7:0]               mean_value;

  // accept-time decode
  logic                     in_fire, out_free, wr_step, emit_held, emit_job, hold_job;
  logic [13:0]              bytes;
  logic [tnd_pkg::ColW-1:0] nb_dist;
  logic                     row_end, first_row, last_row;
  logic                     j0_en, j1_en;
  tnd_pkg::job_t            j0, j1, j2;
  logic [2:0]               n_res;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    bytes     = ilv_r ? {line_len_r, 1'b0} : {1'b0, line_len_r};
    nb_dist   = ilv_r ? 13'd2 : 13'd1;
    row_end   = ({1'b0, col_r} + 14'd1) >= bytes;
    first_row = (row_r == '0);
    last_row  = ({1'b0, row_r} + 13'd1) >= frame_rows_r;

    // byte one neighbor distance back, its right neighbor just arrived
    j0_en        = col_r >= nb_dist;
    j0.k         = col_r - nb_dist;
    j0.center    = ilv_r ? ow_r[1] : ow_r[0];
    j0.left      = ilv_r ? ow_r[3] : ow_r[1];
    j0.has_left  = j0.k >= nb_dist;
    j0.right     = in_center_value;
    j0.has_right = 1'b1;
    j0.down      = last_row ? j0.center : (ilv_r ? bw_r[1] : bw_r[0]);
    j0.eol       = 1'b0;
    j0.eof       = 1'b0;

    // interleaved row end: previous byte has no right neighbor
    j1_en        = row_end && ilv_r && (col_r != '0);
    j1.k         = col_r - 13'd1;
    j1.center    = ow_r[0];
    j1.left      = ow_r[2];
    j1.has_left  = j1.k >= 13'd2;
    j1.right     = 8'd0;
    j1.has_right = 1'b0;
    j1.down      = last_row ? ow_r[0] : bw_r[0];
    j1.eol       = 1'b0;
    j1.eof       = 1'b0;

    // row end: current byte closes the row
    j2.k         = col_r;
    j2.center    = in_center_value;
    j2.left      = ilv_r ? ow_r[1] : ow_r[0];
    j2.has_left  = col_r >= nb_dist;
    j2.right     = 8'd0;
    j2.has_right = 1'b0;
    j2.down      = last_row ? in_center_value : in_below_value;
    j2.eol       = 1'b1;
    j2.eof       = last_row;

    n_res = {2'b00, held_valid_r} + {2'b00, j0_en} + {2'b00, j1_en} + {2'b00, row_end};
  end

  // lowest pending job goes next
  always_comb begin
    if (pend_r[0]) begin
      sel_idx = 2'd0;
    end else if (pend_r[1]) begin
      sel_idx = 2'd1;
    end else begin
      sel_idx = 2'd2;
    end
    sel_job = jobs_r[sel_idx];
  end

  assign emit_held = (state_r == ST_HELD) && out_free;
  assign wr_step   = (state_r == ST_WR) && (pos_r[1] || out_free);
  assign emit_job  = wr_step && !pos_r[1];
  assign hold_job  = wr_step && (pos_r == 2'd2);

  always_comb begin
    state_nxt      = state_r;
    pend_nxt       = pend_r;
    held_valid_nxt = held_valid_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          pend_nxt = {row_end, j1_en, j0_en};
          if (held_valid_r) begin
            state_nxt = ST_HELD;
          end else if (j0_en || row_end) begin
            state_nxt = ST_RD;
          end
          if (row_end) begin
            col_nxt = '0;
            row_nxt = last_row ? '0 : (row_r + 12'd1);
          end else begin
            col_nxt = col_r + 13'd1;
          end
        end
      end
      ST_HELD: begin
        if (emit_held) begin
          held_valid_nxt = 1'b0;
          state_nxt      = (pend_r != '0) ? ST_RD : ST_IDLE;
        end
      end
      ST_RD: begin
        pend_nxt[sel_idx] = 1'b0;
        state_nxt         = ST_CALC;
      end
      ST_CALC: begin
        state_nxt = ST_WR;
      end
      ST_WR: begin
        if (wr_step) begin
          if (hold_job) begin
            held_valid_nxt = 1'b1;
          end
          state_nxt = (pend_r != '0) ? ST_RD : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_r       <= '0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      thr_r        <= tnd_pkg::thr_of(7'd1);
      line_len_r   <= 13'd1;
      frame_rows_r <= 13'd1;
      ilv_r        <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        ow_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        bw_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      pend_r       <= pend_nxt;
      held_valid_r <= held_valid_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      if (emit_held || emit_job) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        ow_r[3] <= ow_r[2];
        ow_r[2] <= ow_r[1];
        ow_r[1] <= ow_r[0];
        ow_r[0] <= in_center_value;
        bw_r[2] <= bw_r[1];
        bw_r[1] <= bw_r[0];
        bw_r[0] <= in_below_value;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          tnd_pkg::CfgStrength:    thr_r <= tnd_pkg::thr_of(tnd_pkg::clamp_strength(cfg_data));
          tnd_pkg::CfgLineLength:  line_len_r <= tnd_pkg::clamp_len(cfg_data);
          tnd_pkg::CfgFrameRows:   frame_rows_r <= tnd_pkg::clamp_len(cfg_data);
          tnd_pkg::CfgInterleaved: ilv_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // payload and job bookkeeping
  always_ff @(posedge clk) begin
    if (in_fire) begin
      jobs_r[0]   <= j0;
      jobs_r[1]   <= j1;
      jobs_r[2]   <= j2;
      first_row_r <= first_row;
      last_pos_r  <= (n_res >= 3'd2);
      pos_r       <= 2'd0;
    end
    if (state_r == ST_RD) begin
      cur_r <= sel_job;
    end
    if (emit_held) begin
      out_value_r <= held_value_r;
      out_eol_r   <= held_eol_r;
      out_eof_r   <= held_eof_r;
      out_last_r  <= !last_pos_r;
      pos_r       <= 2'd1;
    end
    if (emit_job) begin
      out_value_r <= mean_value;
      out_eol_r   <= cur_r.eol;
      out_eof_r   <= cur_r.eof;
      out_last_r  <= (pos_r[0] == last_pos_r);
    end
    if (hold_job) begin
      held_value_r <= mean_value;
      held_eol_r   <= cur_r.eol;
      held_eof_r   <= cur_r.eof;
    end
    if (wr_step && (pos_r != 2'd3)) begin
      pos_r <= pos_r + 2'd1;
    end
  end

  // row store: read in the read step, written back in the write-back step of
  // the same job, so a read never overlaps a write
  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      rd_data_r <= store_mem[sel_job.k];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_step) begin
      store_mem[cur_r.k] <= mean_value;
    end
  end

  tnd_mean u_mean (
    .clk        (clk),
    .calc_en    (state_r == ST_CALC),
    .job        (cur_r),
    .up_value   (rd_data_r),
    .first_row  (first_row_r),
    .thr        (thr_r),
    .mean_value (mean_value)
  );

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;
  assign out_end_of_line    = out_eol_r;
  assign out_end_of_frame   = out_eof_r;
  assign out_last_of_run    = out_last_r;

  a_idle_no_jobs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (pend_r == '0))
    else $error("jobs pending while idle");

  a_held_at_row_start: assert property (@(posedge clk) disable iff (!rst_n)
    (held_valid_r && (state_r == ST_IDLE)) |-> (col_r == '0))
    else $error("held byte outside a row start");

  a_eof_has_eol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_frame) |-> out_end_of_line)
    else $error("frame end without line end");

endmodule
